// ----- hdl/qoa_pkg.sv -----
package qoa_pkg;

    localparam int unsigned MAX_CHANNELS_DEF  = 8;
    localparam int unsigned SAMPLES_PER_SLICE = 20;
    localparam int unsigned TAPS              = 4;
    localparam int unsigned SAMPLE_W          = 16;
    localparam int unsigned IDX_BITS          = 5;
    localparam int unsigned CODE_BITS         = 3;
    localparam int unsigned CODES_W           = SAMPLES_PER_SLICE * CODE_BITS;
    localparam int unsigned ENTRY_W           = 2 * TAPS * SAMPLE_W;
    localparam int unsigned IN_DATA_W         = 200;
    localparam int unsigned OUT_DATA_W        = 24;

    // Values of the request kind on s_tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SAMPLES_PER_SLICE - 1);

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_ACC  = 5'b01000,
        ST_WRB  = 5'b10000
    } state_t;

    // round((q+1)^2.75)
    function automatic logic [11:0] scale_factor(input logic [3:0] q);
        logic [11:0] sf;
        begin
            case (q)
                4'd0:    sf = 12'd1;
                4'd1:    sf = 12'd7;
                4'd2:    sf = 12'd21;
                4'd3:    sf = 12'd45;
                4'd4:    sf = 12'd84;
                4'd5:    sf = 12'd138;
                4'd6:    sf = 12'd211;
                4'd7:    sf = 12'd304;
                4'd8:    sf = 12'd421;
                4'd9:    sf = 12'd562;
                4'd10:   sf = 12'd731;
                4'd11:   sf = 12'd928;
                4'd12:   sf = 12'd1157;
                4'd13:   sf = 12'd1419;
                4'd14:   sf = 12'd1715;
                default: sf = 12'd2048;
            endcase
            return sf;
        end
    endfunction

    // Dequantizer multiplier in quarters: 0.75, 2.5, 4.5, 7
    function automatic logic [4:0] quarters(input logic [2:0] code);
        logic [4:0] qm;
        begin
            case (code[2:1])
                2'd0:    qm = 5'd3;
                2'd1:    qm = 5'd10;
                2'd2:    qm = 5'd18;
                default: qm = 5'd28;
            endcase
            return qm;
        end
    endfunction

    // Residual, rounded half away from zero; odd codes are negative
    function automatic logic signed [15:0] dequant(input logic [3:0] sfi,
                                                  input logic [2:0] code);
        logic [16:0] prod;
        logic [14:0] mag;
        logic signed [15:0] res;
        begin
            prod = 17'(scale_factor(sfi)) * 17'(quarters(code)) + 17'd2;
            mag  = prod[16:2];
            res  = code[0] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            return res;
        end
    endfunction

endpackage

// ----- hdl/qoa_slice_decoder.sv -----
// QOA slice decoder. A load request (s_tuser = 0) writes one channel's four
// history samples and four LMS weights into the state memory. A decode
// request (s_tuser = 1) reads the channel's state, then runs the twenty
// predictor steps of the slice (the four tap products and the residual are
// registered, then summed, saturated and shifted into the history while the
// weights are updated), and writes the state back. A sample that is still
// waiting on the output when the next one is ready holds the sequencer
// until the output register is free. The output register lets the next
// request be taken while the last sample still waits. A channel at or
// above MAX_CHANNELS is accepted and dropped. The state memory holds no
// defined value for a channel until it has been loaded.
module qoa_slice_decoder #(
    parameter int unsigned MAX_CHANNELS = qoa_pkg::MAX_CHANNELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // channel[2:0], slice_word[66:3], hist_0..hist_3[130:67],
    // weight_0..weight_3[194:131], zero pad[199:195]
    input  logic [qoa_pkg::IN_DATA_W-1:0]    s_tdata,
    // op
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // sample[15:0], out_channel[18:16], sample_index[23:19]
    output logic [qoa_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);

    localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned SW    = qoa_pkg::SAMPLE_W;
    localparam int unsigned TAPS  = qoa_pkg::TAPS;

    // Request fields
    logic [2:0]  in_channel;
    logic [63:0] in_slice;
    logic [7:0]  ch_ext;
    logic [IDX_W-1:0] in_idx;
    logic        ch_ok;
    logic        accept;

    assign in_channel = s_tdata[2:0];
    assign in_slice   = s_tdata[66:3];
    assign ch_ext     = {5'b0, in_channel};
    assign in_idx     = ch_ext[IDX_W-1:0];
    assign ch_ok      = {1'b0, ch_ext} < 9'(MAX_CHANNELS);
    assign accept     = s_tvalid && s_tready;

    // Control registers
    qoa_pkg::state_t state_reg, state_next;
    logic [qoa_pkg::IDX_BITS-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    // Working copy of the channel state and per-slice payload
    logic signed [SW-1:0] hist_reg [TAPS];
    logic signed [SW-1:0] wgt_reg  [TAPS];
    logic signed [31:0]   prod_reg [TAPS];
    logic signed [SW-1:0] res_reg;
    logic [qoa_pkg::CODES_W-1:0] codes_reg;
    logic [3:0]           sfi_reg;
    logic [2:0]           ch_reg;
    logic [IDX_W-1:0]     idx_reg;

    // Output register payload
    logic [SW-1:0]        out_sample_reg;
    logic [2:0]           out_ch_reg;
    logic [qoa_pkg::IDX_BITS-1:0] out_idx_reg;
    logic                 out_last_reg;

    // State memory: {weights 3..0, history 3..0}, one row per channel
    logic [qoa_pkg::ENTRY_W-1:0] mem [MAX_CHANNELS];
    logic [qoa_pkg::ENTRY_W-1:0] mem_rd_reg;
    logic [qoa_pkg::ENTRY_W-1:0] wr_data;
    logic [qoa_pkg::ENTRY_W-1:0] wb_data;
    logic [IDX_W-1:0]            wr_addr;
    logic                        mem_we;
    logic                        load_we;
    logic                        rd_en;

    assign load_we = accept && (s_tuser == qoa_pkg::OP_LOAD) && ch_ok;
    assign rd_en   = accept && (s_tuser == qoa_pkg::OP_DECODE) && ch_ok;
    assign mem_we  = load_we || (state_reg == qoa_pkg::ST_WRB);
    assign wr_addr = load_we ? in_idx : idx_reg;
    assign wr_data = load_we ? s_tdata[194:67] : wb_data;

    always_comb
    begin
        for (int n = 0; n < TAPS; n++)
        begin
            wb_data[n*SW +: SW]          = hist_reg[n];
            wb_data[(TAPS+n)*SW +: SW]   = wgt_reg[n];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[in_idx];
        end
    end

    // Predictor step: sum, round down, add residual, saturate
    logic signed [33:0]   acc_sum;
    logic signed [20:0]   pred;
    logic signed [21:0]   sum_full;
    logic signed [SW-1:0] sample_sat;
    logic signed [SW-1:0] delta;
    logic                 advance;

    always_comb
    begin
        acc_sum = 34'(prod_reg[0]) + 34'(prod_reg[1])
                + 34'(prod_reg[2]) + 34'(prod_reg[3]);
        pred     = 21'(acc_sum >>> 13);
        sum_full = 22'(pred) + 22'(res_reg);
        if (sum_full > 22'sd32767)
        begin
            sample_sat = 16'sh7fff;
        end
        else if (sum_full < -22'sd32768)
        begin
            sample_sat = 16'sh8000;
        end
        else
        begin
            sample_sat = sum_full[15:0];
        end
        delta = res_reg >>> 4;
    end

    assign advance = !out_valid_reg || m_tready;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            qoa_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (rd_en)
                begin
                    state_next = qoa_pkg::ST_READ;
                end
            end
            qoa_pkg::ST_READ:
            begin
                state_next = qoa_pkg::ST_MUL;
            end
            qoa_pkg::ST_MUL:
            begin
                state_next = qoa_pkg::ST_ACC;
            end
            qoa_pkg::ST_ACC:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    if (cnt_reg == qoa_pkg::LAST_IDX)
                    begin
                        state_next = qoa_pkg::ST_WRB;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = qoa_pkg::ST_MUL;
                    end
                end
            end
            qoa_pkg::ST_WRB:
            begin
                state_next = qoa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = qoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qoa_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            codes_reg <= in_slice[qoa_pkg::CODES_W-1:0];
            sfi_reg   <= in_slice[63:60];
            ch_reg    <= in_channel;
            idx_reg   <= in_idx;
        end
        case (state_reg)
            qoa_pkg::ST_READ:
            begin
                for (int n = 0; n < TAPS; n++)
                begin
                    hist_reg[n] <= mem_rd_reg[n*SW +: SW];
                    wgt_reg[n]  <= mem_rd_reg[(TAPS+n)*SW +: SW];
                end
            end
            qoa_pkg::ST_MUL:
            begin
                for (int n = 0; n < TAPS; n++)
                begin
                    prod_reg[n] <= hist_reg[n] * wgt_reg[n];
                end
                res_reg <= qoa_pkg::dequant(sfi_reg,
                               codes_reg[qoa_pkg::CODES_W-1 -: qoa_pkg::CODE_BITS]);
            end
            qoa_pkg::ST_ACC:
            begin
                if (advance)
                begin
                    // sign-LMS update on the old history, then shift in
                    for (int n = 0; n < TAPS; n++)
                    begin
                        wgt_reg[n] <= hist_reg[n][SW-1] ? wgt_reg[n] - delta
                                                        : wgt_reg[n] + delta;
                    end
                    for (int n = 0; n < TAPS - 1; n++)
                    begin
                        hist_reg[n] <= hist_reg[n+1];
                    end
                    hist_reg[TAPS-1] <= sample_sat;
                    codes_reg        <= codes_reg << qoa_pkg::CODE_BITS;
                    out_sample_reg   <= sample_sat;
                    out_ch_reg       <= ch_reg;
                    out_idx_reg      <= cnt_reg;
                    out_last_reg     <= (cnt_reg == qoa_pkg::LAST_IDX);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == qoa_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_idx_reg, out_ch_reg, out_sample_reg};
    assign m_tlast  = out_last_reg;

    // Checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qoa_pkg::ST_ACC) |-> (cnt_reg <= qoa_pkg::LAST_IDX))
        else $error("sample counter past end of slice");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[23:19] == qoa_pkg::LAST_IDX)))
        else $error("tlast does not match sample index");

    a_wrb_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qoa_pkg::ST_WRB) |-> ($past(state_reg) == qoa_pkg::ST_ACC))
        else $error("write-back without a finished slice");

    a_we_when: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == qoa_pkg::ST_IDLE) || (state_reg == qoa_pkg::ST_WRB)))
        else $error("state memory written mid-slice");

endmodule

// ----- test/testbench.sv -----
module testbench;

    // One request as the block sees it
    typedef struct packed {
        logic                           op;
        logic [2:0]                     ch;
        logic [63:0]                    word;
        logic [qoa_pkg::TAPS-1:0][15:0] hist;   // [0] is the oldest tap
        logic [qoa_pkg::TAPS-1:0][15:0] wt;
    } request_t;

    // Directed row: a request plus an optional hand-typed first sample
    typedef struct {
        request_t           req;
        bit                 hand;
        logic signed [15:0] first_pcm;
    } row_t;

    // One decoded sample on the output stream
    typedef struct {
        logic signed [15:0] pcm;
        logic [2:0]         chan;
        logic [4:0]         idx;
        logic               last;
    } pcm_result_t;

    localparam int unsigned RANDOM_REQUESTS = 300;
    localparam int unsigned CALM_FROM       = 260;
    localparam int unsigned DRAIN_CYCLES    = 100;

    // round((q+1)^2.75) and dequantizer steps in quarters
    localparam int SF_TABLE [16] = '{1, 7, 21, 45, 84, 138, 211, 304,
                                     421, 562, 731, 928, 1157, 1419, 1715, 2048};
    localparam int QUARTER_TABLE [4] = '{3, 10, 18, 28};

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [qoa_pkg::IN_DATA_W-1:0]    s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [qoa_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                             m_tlast;

    // Shadow LMS state per channel
    logic [qoa_pkg::TAPS-1:0][15:0] chan_hist [qoa_pkg::MAX_CHANNELS_DEF];
    logic [qoa_pkg::TAPS-1:0][15:0] chan_wt   [qoa_pkg::MAX_CHANNELS_DEF];

    pcm_result_t pending_pcm [$];
    row_t        directed_rows [$];
    int          mismatch_count;
    bit          idle_on;
    int          stall_left;

    qoa_slice_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    // Run the twenty LMS steps of one slice and queue the samples
    task automatic predict_slice(input logic [2:0] ch, input logic [63:0] word,
                                 input bit hand, input logic signed [15:0] first_pcm);
        logic [3:0]  sfi;
        logic [2:0]  code;
        int          mag;
        int          resid;
        int          delta;
        longint      acc;
        longint      pcm;
        pcm_result_t e;
        sfi = word[63:60];
        for (int i = 0; i < qoa_pkg::SAMPLES_PER_SLICE; i++)
        begin
            code  = word[(59 - 3 * i) -: 3];
            mag   = (SF_TABLE[sfi] * QUARTER_TABLE[code[2:1]] + 2) / 4;
            resid = code[0] ? -mag : mag;
            acc   = 0;
            for (int n = 0; n < qoa_pkg::TAPS; n++)
                acc += longint'($signed(chan_hist[ch][n])) * longint'($signed(chan_wt[ch][n]));
            pcm = (acc >>> 13) + resid;
            if (pcm > 32767)
                pcm = 32767;
            else if (pcm < -32768)
                pcm = -32768;
            // sign-LMS update, weights wrap at 16 bits
            delta = resid >>> 4;
            for (int n = 0; n < qoa_pkg::TAPS; n++)
            begin
                if ($signed(chan_hist[ch][n]) < 0)
                    chan_wt[ch][n] = chan_wt[ch][n] - delta[15:0];
                else
                    chan_wt[ch][n] = chan_wt[ch][n] + delta[15:0];
            end
            for (int n = 0; n < qoa_pkg::TAPS - 1; n++)
                chan_hist[ch][n] = chan_hist[ch][n + 1];
            chan_hist[ch][qoa_pkg::TAPS - 1] = pcm[15:0];
            e.pcm  = (hand && i == 0) ? first_pcm : pcm[15:0];
            e.chan = ch;
            e.idx  = i[4:0];
            e.last = (i == qoa_pkg::SAMPLES_PER_SLICE - 1);
            pending_pcm = {pending_pcm, e};
        end
    endtask

    // Present one request, wait for the handshake, then update the shadow state
    task automatic issue_request(input request_t r, input bit hand,
                                 input logic signed [15:0] first_pcm);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = r.op;
        s_tdata  = {5'b0, r.wt, r.hist, r.word, r.ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (r.ch < qoa_pkg::MAX_CHANNELS_DEF)
        begin
            if (r.op == qoa_pkg::OP_LOAD)
            begin
                chan_hist[r.ch] = r.hist;
                chan_wt[r.ch]   = r.wt;
            end
            else
                predict_slice(r.ch, r.word, hand, first_pcm);
        end
    endtask

    task automatic add_row(input logic op, input logic [2:0] ch, input logic [63:0] word,
                           input logic [qoa_pkg::TAPS-1:0][15:0] hist,
                           input logic [qoa_pkg::TAPS-1:0][15:0] wt,
                           input bit hand, input logic signed [15:0] first_pcm);
        row_t row;
        row.req.op    = op;
        row.req.ch    = ch;
        row.req.word  = word;
        row.req.hist  = hist;
        row.req.wt    = wt;
        row.hand      = hand;
        row.first_pcm = first_pcm;
        directed_rows = {directed_rows, row};
    endtask

    // 16-bit value: extremes now and then, small weights often
    function automatic logic [15:0] rand_tap(input bit is_weight);
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 7))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2: v = is_weight ? 16'h0000 : 16'hFFFF;
            3, 4, 5:
                if (is_weight)
                    v = {{3{v[12]}}, v[12:0]};
            default: ;
        endcase
        return v;
    endfunction

    // Output side: random stall bursts while idling is on
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 16);
            m_tready = (stall_left == 0);
        end
    end

    // Compare each output sample with the oldest pending sample
    always @(posedge clk)
    begin
        pcm_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pcm.size() == 0)
            begin
                $display("%0t: unexpected sample %0d ch %0d idx %0d", $time,
                         $signed(m_tdata[15:0]), m_tdata[18:16], m_tdata[23:19]);
                mismatch_count++;
            end
            else
            begin
                e = pending_pcm.pop_front();
                if ($signed(m_tdata[15:0]) != e.pcm)
                begin
                    $display("%0t: sample expected %0d actual %0d", $time,
                             e.pcm, $signed(m_tdata[15:0]));
                    mismatch_count++;
                end
                if (m_tdata[18:16] != e.chan)
                begin
                    $display("%0t: out_channel expected %0d actual %0d", $time,
                             e.chan, m_tdata[18:16]);
                    mismatch_count++;
                end
                if (m_tdata[23:19] != e.idx)
                begin
                    $display("%0t: sample_index expected %0d actual %0d", $time,
                             e.idx, m_tdata[23:19]);
                    mismatch_count++;
                end
                if (m_tlast != e.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, e.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        request_t r;
        logic [63:0] cyc8;
        logic [63:0] cyc7;
        logic [63:0] cyc3;
        s_tvalid       = 1'b0;
        s_tuser        = qoa_pkg::OP_LOAD;
        s_tdata        = '0;
        rst_n          = 1'b0;
        idle_on        = 1'b1;
        mismatch_count = 0;

        // codes 0..7 in turn under a few scale indexes
        cyc8 = {4'd8, {2{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7}},
                3'd0, 3'd1, 3'd2, 3'd3};
        cyc7 = {4'd7, cyc8[59:0]};
        cyc3 = {4'd3, cyc8[59:0]};

        // zero state: first sample is the bare residual
        add_row(qoa_pkg::OP_LOAD,   3'd0, 64'h0, '0, '0, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_DECODE, 3'd0, 64'h0, '0, '0, 1'b1, 16'sd1);
        add_row(qoa_pkg::OP_LOAD,   3'd1, 64'h0, '0, '0, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_DECODE, 3'd1, {4'hF, {20{3'd0}}}, '0, '0, 1'b1, 16'sd1536);
        add_row(qoa_pkg::OP_LOAD,   3'd2, 64'h0, '0, '0, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_DECODE, 3'd2, '1, '0, '0, 1'b1, -16'sd14336);
        // full-scale state: prediction saturates both ways
        add_row(qoa_pkg::OP_LOAD,   3'd3, 64'h0, {4{16'h7FFF}}, {4{16'h7FFF}}, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_DECODE, 3'd3, {4'hF, {20{3'd6}}}, '0, '0, 1'b1, 16'sd32767);
        add_row(qoa_pkg::OP_LOAD,   3'd4, 64'h0, {4{16'h8000}}, {4{16'h7FFF}}, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_DECODE, 3'd4, '1, '0, '0, 1'b1, -16'sd32768);
        add_row(qoa_pkg::OP_LOAD,   3'd5, 64'h0, {4{16'h8000}}, {4{16'h8000}}, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_DECODE, 3'd5, cyc8, '0, '0, 1'b1, 16'sd32767);
        // mixed signs, every code
        add_row(qoa_pkg::OP_LOAD,   3'd6, 64'h0, {16'hFF00, 16'h0100, 16'hFEDC, 16'h1234},
                {16'hF800, 16'h0800, 16'hE000, 16'h2000}, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_DECODE, 3'd6, cyc7, '0, '0, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_LOAD,   3'd7, 64'h0, {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF},
                {16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF}, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_DECODE, 3'd7, 64'h0123_4567_89AB_CDEF, '0, '0, 1'b0, 16'sd0);
        // state carried over between slices of one channel
        add_row(qoa_pkg::OP_DECODE, 3'd0, 64'h5A5A_A5A5_5A5A_A5A5, '0, '0, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_DECODE, 3'd0, 64'h7FFF_FFFF_0000_0000, '0, '0, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_DECODE, 3'd5, cyc3, '0, '0, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_DECODE, 3'd5, 64'hA492_4924_9249_2492, '0, '0, 1'b0, 16'sd0);
        // load ignores the slice word
        add_row(qoa_pkg::OP_LOAD,   3'd3, '1, {16'h0040, 16'hFFC0, 16'h0010, 16'hFFF0},
                {16'h1000, 16'hF000, 16'h0400, 16'hFC00}, 1'b0, 16'sd0);
        add_row(qoa_pkg::OP_DECODE, 3'd3, {4'd2, {20{3'd5}}}, '1, '1, 1'b0, 16'sd0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[k])
            issue_request(directed_rows[k].req, directed_rows[k].hand,
                          directed_rows[k].first_pcm);

        // Random mix: mostly decodes on loaded channels, some reloads
        for (int k = 0; k < RANDOM_REQUESTS; k++)
        begin
            if (k == CALM_FROM)
                idle_on = 1'b0;
            r.op   = ($urandom_range(0, 3) == 0) ? qoa_pkg::OP_LOAD : qoa_pkg::OP_DECODE;
            r.ch   = 3'($urandom_range(0, 7));
            r.word = {$urandom, $urandom};
            for (int n = 0; n < qoa_pkg::TAPS; n++)
            begin
                r.hist[n] = rand_tap(1'b0);
                r.wt[n]   = rand_tap(1'b1);
            end
            issue_request(r, 1'b0, 16'sd0);
        end

        @(negedge clk);
        s_tvalid = 1'b0;

        while (pending_pcm.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- qoa_slice_decoder.f -----
hdl/qoa_pkg.sv
hdl/qoa_slice_decoder.sv
test/testbench.sv
